FILE: hdl/aes_enc_pkg.sv
// Shared types, constants and round functions for the AES encrypt pipeline.
package aes_enc_pkg;

  localparam int BLOCK_COLUMNS    = 4;
  localparam int KEY_WORDS_DEF    = 60;
  localparam int MIN_ROUNDS       = 10;
  localparam int RC_W             = 4;
  localparam int KEY_IDX_W        = 6;
  localparam int BLOCK_W          = 32 * BLOCK_COLUMNS;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ENCRYPT = 1'b1;

  typedef logic [7:0] byte_t;
  typedef logic [BLOCK_W-1:0] block_t;

  typedef struct packed {
    logic            valid;
    logic [RC_W-1:0] nr;
    block_t          st;
  } stage_t;

  localparam byte_t SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte i = 4*col + row sits at bits [BLOCK_W-1-8i -: 8]
  function automatic byte_t get_byte(block_t s, int i);
    return s[BLOCK_W-1-8*i -: 8];
  endfunction

  function automatic byte_t xtime(byte_t b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic block_t sub_shift(block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < BLOCK_COLUMNS; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%BLOCK_COLUMNS)+r)];
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(block_t s);
    block_t t;
    byte_t a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < BLOCK_COLUMNS; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2);
      a3 = get_byte(s, 4*c+3);
      t[BLOCK_W-1-8*(4*c)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      t[BLOCK_W-1-8*(4*c+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      t[BLOCK_W-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      t[BLOCK_W-1-8*(4*c+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return t;
  endfunction

endpackage

FILE: hdl/aes_enc_if.sv
// Valid/ready channel interfaces for command words and cipher words.
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  key_index;
  logic [31:0] key_word;
  logic [63:0] block_hi;
  logic [63:0] block_lo;
  modport source (output valid, command, key_index, key_word, block_hi, block_lo,
                  input ready);
  modport sink (input valid, command, key_index, key_word, block_hi, block_lo,
                output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_hi;
  logic [63:0] cipher_lo;
  modport source (output valid, cipher_hi, cipher_lo, input ready);
  modport sink (input valid, cipher_hi, cipher_lo, output ready);
endinterface

FILE: hdl/aes_enc_key_store.sv
// Expanded round-key word store; every word is visible to its fixed pipeline stage.
module aes_enc_key_store #(
  parameter int KEY_WORDS = aes_enc_pkg::KEY_WORDS_DEF
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [aes_enc_pkg::KEY_IDX_W-1:0]   widx,
  input  logic [31:0]                         wdata,
  output logic [KEY_WORDS*32-1:0]             words
);
  localparam int AW = $clog2(KEY_WORDS);

  logic [31:0] key_r [KEY_WORDS];

  always_ff @(posedge clk) begin
    if (we && (widx < aes_enc_pkg::KEY_IDX_W'(KEY_WORDS))) begin
      key_r[widx[AW-1:0]] <= wdata;
    end
  end

  always_comb begin
    for (int w = 0; w < KEY_WORDS; w++) begin
      words[KEY_WORDS*32-1-32*w -: 32] = key_r[w];
    end
  end
endmodule

FILE: hdl/aes_enc_round.sv
// One cipher round stage: full round, final round or pass-through per item.
module aes_enc_round #(
  parameter int RND = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  aes_enc_pkg::stage_t         prev,
  input  aes_enc_pkg::block_t         rkey,
  output aes_enc_pkg::stage_t         cur
);
  localparam logic [aes_enc_pkg::RC_W-1:0] RND_C = aes_enc_pkg::RC_W'(RND);

  aes_enc_pkg::stage_t stage_r, stage_nxt;
  aes_enc_pkg::block_t ss;

  always_comb begin
    ss = aes_enc_pkg::sub_shift(prev.st);
    stage_nxt = prev;
    if (RND_C < prev.nr) begin
      stage_nxt.st = aes_enc_pkg::mix_columns(ss) ^ rkey;
    end else if (RND_C == prev.nr) begin
      stage_nxt.st = ss ^ rkey;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r.nr <= stage_nxt.nr;
      stage_r.st <= stage_nxt.st;
    end
  end

  assign cur = stage_r;
endmodule

FILE: hdl/aes_block_encrypt_unit.sv
// Top level of the pipelined AES-128/192/256 block encrypt unit.
// AES forward cipher, ECB. Every round has its own register stage, so one block
// enters per cycle while the pipe advances and passes through an AddRoundKey
// stage, MAX_ROUNDS round stages and the output register before its cipher
// word leaves. Blocks using fewer rounds pass the extra stages unchanged.
// Round keys live in flops, each stage tapping its own four words. A key-load
// word is taken only when no block is in flight (otherwise ready stays low), so
// loads never touch blocks already accepted. round_count is clamped to
// 10..KEY_WORDS/4-1 and sampled per block as it enters. The whole pipe advances
// together and holds when the output register is full and not taken.
module aes_block_encrypt_unit #(
  parameter int KEY_WORDS = aes_enc_pkg::KEY_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aes_enc_pkg::RC_W-1:0]  cfg_wdata,
  aes_in_if.sink                        in_ch,
  aes_out_if.source                     out_ch
);
  localparam int MAX_ROUNDS = KEY_WORDS / aes_enc_pkg::BLOCK_COLUMNS - 1;
  localparam int BW = aes_enc_pkg::BLOCK_W;

  logic [aes_enc_pkg::RC_W-1:0] round_count_r;
  logic [aes_enc_pkg::RC_W-1:0] nr_clamped;
  logic [KEY_WORDS*32-1:0]      key_words;
  aes_enc_pkg::stage_t          stg [MAX_ROUNDS+1];
  aes_enc_pkg::stage_t          stg0_r;
  logic                         out_valid_r;
  aes_enc_pkg::block_t          out_data_r;
  logic                         en, busy, accept, load_we;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      round_count_r <= aes_enc_pkg::RC_W'(aes_enc_pkg::MIN_ROUNDS);
    end else if (cfg_we) begin
      round_count_r <= cfg_wdata;
    end
  end

  always_comb begin
    nr_clamped = round_count_r;
    if (round_count_r < aes_enc_pkg::RC_W'(aes_enc_pkg::MIN_ROUNDS)) begin
      nr_clamped = aes_enc_pkg::RC_W'(aes_enc_pkg::MIN_ROUNDS);
    end else if (round_count_r > aes_enc_pkg::RC_W'(MAX_ROUNDS)) begin
      nr_clamped = aes_enc_pkg::RC_W'(MAX_ROUNDS);
    end
  end

  // pipe advance and input handshake
  assign en = !out_valid_r || out_ch.ready;

  always_comb begin
    busy = 1'b0;
    for (int i = 0; i <= MAX_ROUNDS; i++) begin
      busy = busy | stg[i].valid;
    end
  end

  assign in_ch.ready = en && ((in_ch.command == aes_enc_pkg::CMD_ENCRYPT) || !busy);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_we     = accept && (in_ch.command == aes_enc_pkg::CMD_LOAD);

  aes_enc_key_store #(.KEY_WORDS(KEY_WORDS)) u_keys (
    .clk   (clk),
    .we    (load_we),
    .widx  (in_ch.key_index),
    .wdata (in_ch.key_word),
    .words (key_words)
  );

  // stage 0: initial AddRoundKey
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg0_r.valid <= 1'b0;
    end else if (en) begin
      stg0_r.valid <= accept && (in_ch.command == aes_enc_pkg::CMD_ENCRYPT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg0_r.nr <= nr_clamped;
      stg0_r.st <= {in_ch.block_hi, in_ch.block_lo} ^ key_words[KEY_WORDS*32-1 -: BW];
    end
  end

  assign stg[0] = stg0_r;

  // round stages
  for (genvar r = 1; r <= MAX_ROUNDS; r++) begin : g_round
    aes_enc_round #(.RND(r)) u_round (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .prev  (stg[r-1]),
      .rkey  (key_words[KEY_WORDS*32-1-BW*r -: BW]),
      .cur   (stg[r])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg[MAX_ROUNDS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= stg[MAX_ROUNDS].st;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.cipher_hi = out_data_r[BW-1 -: 64];
  assign out_ch.cipher_lo = out_data_r[63:0];
endmodule
